### sv/ddo_pkg.sv
package ddo_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_MEAN,
        S_TW0,
        S_TW1,
        S_TW2,
        S_RK0,
        S_RK1,
        S_RK2,
        S_ROT,
        S_CORDIC,
        S_UPD,
        S_EMIT
    } t_state;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = $clog2(ATAN_ENTRIES);
    localparam int MUL_W            = 33;
    localparam int CORDIC_W         = 36;

    localparam logic CFG_DPT = 1'b0;
    localparam logic CFG_ITW = 1'b1;

    localparam logic [31:0] DPT_RESET   = 32'd2055142;
    localparam logic [31:0] ITW_RESET   = 32'd6554;
    localparam logic [31:0] RAD_TO_TURN = 32'd683565276;
    localparam logic [31:0] INV_GAIN    = 32'd2608131496;

    // atan(2^-i) as a fraction of a full turn, 32 fraction bits
    localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### sv/ddo_mul.sv
module ddo_mul (
    input  logic                                  i_clk,
    input  logic signed [ddo_pkg::MUL_W-1:0]      i_a,
    input  logic signed [ddo_pkg::MUL_W-1:0]      i_b,
    output logic signed [2*ddo_pkg::MUL_W-1:0]    o_prod
);
    import ddo_pkg::*;

    logic signed [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### sv/ddo_cordic.sv
module ddo_cordic #(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [31:0]                    i_mag,
    input  logic        [31:0]                    i_angle,
    output logic                                  o_done,
    output logic signed [ddo_pkg::CORDIC_W-1:0]   o_x,
    output logic signed [ddo_pkg::CORDIC_W-1:0]   o_y
);
    import ddo_pkg::*;

    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_step;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;

    logic [31:0]                w_shift_ang;
    logic                       w_flip;
    logic [31:0]                w_ang;
    logic signed [CORDIC_W-1:0] w_mag;
    logic signed [CORDIC_W-1:0] w_x0;
    logic signed [CORDIC_W-1:0] w_sx;
    logic signed [CORDIC_W-1:0] w_sy;
    logic signed [CORDIC_W-1:0] w_atan;
    logic                       w_last;

    // left half-plane: negate the vector and turn the angle by half a turn
    assign w_shift_ang = i_angle + 32'h40000000;
    assign w_flip      = w_shift_ang[31];
    assign w_ang       = w_flip ? {~i_angle[31], i_angle[30:0]} : i_angle;
    assign w_mag       = {{(CORDIC_W-32){i_mag[31]}}, i_mag};
    assign w_x0        = w_flip ? -w_mag : w_mag;

    assign w_sx   = r_x >>> r_step;
    assign w_sy   = r_y >>> r_step;
    assign w_atan = {{(CORDIC_W-32){1'b0}}, ATAN_TURN[ATAN_IDX_W'(r_step)]};
    assign w_last = (r_step == STEP_W'(STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= w_x0;
            r_y <= '0;
            r_z <= {{(CORDIC_W-32){w_ang[31]}}, w_ang};
        end else if (r_busy) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - w_sy;
                r_y <= r_y + w_sx;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_sy;
                r_y <= r_y - w_sx;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

### sv/differential_drive_odometry.sv
// Differential drive wheel odometry.
// Input channel: running left/right encoder counts (i_in_valid / o_in_stall).
// Output channel: pose x, y (Q16.16 m, saturating) and heading (binary angle),
// one beat per input beat (o_out_valid / i_out_stall).
// Config port: i_cfg_we with index 0 = distance per tick, 1 = inverse track
// width; write only while the block is idle.
// An item runs through one shared 33x33 multiplier (seven products in
// sequence) and then an iterative CORDIC of CORDIC_STEPS steps. The pose is
// updated in S_UPD and the result beat is registered from S_EMIT once the
// output register is free; the next item is taken only back in S_IDLE.
// The first item after reset only latches the counts and returns a zero
// pose through S_EMIT.
// o_in_stall is high while an item is in work. A finished result waits in
// the output register; a new item may be taken while it waits, but that item
// cannot finish until the pending beat has gone.
// Reset clears the pose, the previous counts and the start flag, and loads
// the register defaults.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_right_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic        [15:0] o_heading,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic        [31:0] i_cfg_data
);
    import ddo_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [31:0]        r_dpt;
    logic [31:0]        r_itw;
    logic               r_started;
    logic [31:0]        r_last_l;
    logic [31:0]        r_last_r;
    logic signed [31:0] r_x_acc;
    logic signed [31:0] r_y_acc;
    logic [31:0]        r_h_acc;
    logic               r_out_valid;

    logic signed [31:0] r_dcl;
    logic signed [31:0] r_dcr;
    logic signed [47:0] r_dl;
    logic signed [47:0] r_dr;
    logic signed [31:0] r_mean;
    logic [63:0]        r_acc;
    logic signed [31:0] r_gain;
    logic [47:0]        r_turn;
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic [15:0]        r_out_h;

    logic                       w_accept;
    logic                       w_out_free;
    logic signed [MUL_W-1:0]    w_mul_a;
    logic signed [MUL_W-1:0]    w_mul_b;
    logic signed [2*MUL_W-1:0]  w_prod;
    logic signed [48:0]         w_sum;
    logic signed [48:0]         w_diff;
    logic [31:0]                w_dturn;
    logic [31:0]                w_mid;
    logic                       w_cordic_start;
    logic                       w_cordic_done;
    logic signed [CORDIC_W-1:0] w_cx;
    logic signed [CORDIC_W-1:0] w_cy;
    logic signed [47:0]         w_x_sum;
    logic signed [47:0]         w_y_sum;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_sum   = {r_dl[47], r_dl} + {r_dr[47], r_dr};
    assign w_diff  = {r_dr[47], r_dr} - {r_dl[47], r_dl};
    assign w_dturn = r_turn[47:16];
    // midpoint heading: half the change, floor
    assign w_mid   = r_h_acc + {w_dturn[31], w_dturn[31:1]};

    assign w_x_sum = {{16{r_x_acc[31]}}, r_x_acc} + {{(48-CORDIC_W){w_cx[CORDIC_W-1]}}, w_cx};
    assign w_y_sum = {{16{r_y_acc[31]}}, r_y_acc} + {{(48-CORDIC_W){w_cy[CORDIC_W-1]}}, w_cy};

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cordic_start),
        .i_mag   (r_gain),
        .i_angle (w_mid),
        .o_done  (w_cordic_done),
        .o_x     (w_cx),
        .o_y     (w_cy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        w_cordic_start = 1'b0;
        w_mul_a        = '0;
        w_mul_b        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_started ? S_MUL_L : S_EMIT;
                end
            end
            S_MUL_L: begin
                w_mul_a = {r_dcl[31], r_dcl};
                w_mul_b = {1'b0, r_dpt};
                n_state = S_MUL_R;
            end
            S_MUL_R: begin
                w_mul_a = {r_dcr[31], r_dcr};
                w_mul_b = {1'b0, r_dpt};
                n_state = S_MEAN;
            end
            S_MEAN: begin
                n_state = S_TW0;
            end
            S_TW0: begin
                // (dr - dl) * itw, low 24 bits of the difference
                w_mul_a = {9'b0, w_diff[23:0]};
                w_mul_b = {1'b0, r_itw};
                n_state = S_TW1;
            end
            S_TW1: begin
                w_mul_a = {{8{w_diff[48]}}, w_diff[48:24]};
                w_mul_b = {1'b0, r_itw};
                n_state = S_TW2;
            end
            S_TW2: begin
                w_mul_a = {r_mean[31], r_mean};
                w_mul_b = {1'b0, INV_GAIN};
                n_state = S_RK0;
            end
            S_RK0: begin
                w_mul_a = {9'b0, r_acc[39:16]};
                w_mul_b = {1'b0, RAD_TO_TURN};
                n_state = S_RK1;
            end
            S_RK1: begin
                w_mul_a = {9'b0, r_acc[63:40]};
                w_mul_b = {1'b0, RAD_TO_TURN};
                n_state = S_RK2;
            end
            S_RK2: begin
                n_state = S_ROT;
            end
            S_ROT: begin
                w_cordic_start = 1'b1;
                n_state        = S_CORDIC;
            end
            S_CORDIC: begin
                if (w_cordic_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // config, pose and handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpt       <= DPT_RESET;
            r_itw       <= ITW_RESET;
            r_started   <= 1'b0;
            r_last_l    <= '0;
            r_last_r    <= '0;
            r_x_acc     <= '0;
            r_y_acc     <= '0;
            r_h_acc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DPT: r_dpt <= i_cfg_data;
                    CFG_ITW: r_itw <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_last_l <= i_left_count;
                r_last_r <= i_right_count;
                if (!r_started) begin
                    r_started <= 1'b1;
                    r_x_acc   <= '0;
                    r_y_acc   <= '0;
                    r_h_acc   <= '0;
                end
            end
            if (r_state == S_UPD) begin
                r_x_acc <= sat32(w_x_sum);
                r_y_acc <= sat32(w_y_sum);
                r_h_acc <= r_h_acc + w_dturn;
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dcl <= i_left_count - r_last_l;
            r_dcr <= i_right_count - r_last_r;
        end
        case (r_state)
            S_MUL_R: r_dl   <= w_prod[63:16];
            S_MEAN:  r_dr   <= w_prod[63:16];
            S_TW0:   r_mean <= sat32(w_sum[48:1]);
            S_TW1:   r_acc  <= w_prod[63:0];
            S_TW2:   r_acc  <= r_acc + {w_prod[39:0], 24'b0};
            S_RK0:   r_gain <= w_prod[63:32];
            S_RK1:   r_turn <= w_prod[47:0];
            S_RK2:   r_turn <= r_turn + {w_prod[23:0], 24'b0};
            default: ;
        endcase
        if (r_state == S_EMIT && w_out_free) begin
            r_out_x <= r_x_acc;
            r_out_y <= r_y_acc;
            r_out_h <= r_h_acc[31:16];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_heading   = r_out_h;

endmodule

### tb/sv/tb_differential_drive_odometry.sv
`timescale 1ns / 100ps

localparam logic [31:0] DPT_AT_RESET    = 32'd2055142;
localparam logic [31:0] ITW_AT_RESET    = 32'd6554;
localparam logic [63:0] RAD_TO_TURN_Q16 = 64'd683565276;
localparam logic [31:0] INV_GAIN_Q32    = 32'd2608131496;

typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
} pose_t;

// Tracks the pose the block should report and checks each pose beat in order.
class pose_tracker;
    int unsigned steps;
    logic [31:0] dist_per_tick;
    logic [31:0] inv_track;
    bit          started;
    logic [31:0] last_left;
    logic [31:0] last_right;
    logic [31:0] x_acc;
    logic [31:0] y_acc;
    logic [31:0] heading_acc;
    logic [31:0] atan_tab [24];
    pose_t       poses_due [$];
    int unsigned errors;
    int unsigned checked;

    function new(int unsigned n_steps);
        steps         = n_steps;
        dist_per_tick = DPT_AT_RESET;
        inv_track     = ITW_AT_RESET;
        started       = 1'b0;
        last_left     = '0;
        last_right    = '0;
        x_acc         = '0;
        y_acc         = '0;
        heading_acc   = '0;
        errors        = 0;
        checked       = 0;
        // atan(2^-k) in turns, 32 fraction bits
        atan_tab = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
        };
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
        if (idx == ddo_pkg::CFG_DPT) begin
            dist_per_tick = val;
        end else begin
            inv_track = val;
        end
    endfunction

    function int pending();
        return poses_due.size();
    endfunction

    function longint sat_q16(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function void queue_pose();
        pose_t p;
        p.pos_x   = x_acc;
        p.pos_y   = y_acc;
        p.heading = heading_acc[31:16];
        poses_due.push_back(p);
    endfunction

    function void note_counts(logic [31:0] left, logic [31:0] right);
        longint             dl, dr, mean, cx, cy, z, sx, sy, tmp;
        logic [63:0]        twist, rad, turn_q;
        logic [31:0]        dturn, mid, quad;
        logic signed [31:0] half_turn;
        if (!started) begin
            // first beat latches the counts and starts from the origin
            started     = 1'b1;
            last_left   = left;
            last_right  = right;
            x_acc       = '0;
            y_acc       = '0;
            heading_acc = '0;
            queue_pose();
            return;
        end
        dl = (longint'($signed(left - last_left)) * longint'(dist_per_tick)) >>> 16;
        dr = (longint'($signed(right - last_right)) * longint'(dist_per_tick)) >>> 16;
        last_left  = left;
        last_right = right;
        mean = sat_q16((dl + dr) >>> 1);

        // heading change, exact modulo one turn
        twist  = dr - dl;
        rad    = (twist * {32'd0, inv_track}) >> 16;
        turn_q = (rad * RAD_TO_TURN_Q16) >> 16;
        dturn  = turn_q[31:0];
        half_turn = $signed(dturn) >>> 1;
        mid = heading_acc + half_turn;

        cx = (mean * longint'(INV_GAIN_Q32)) >>> 32;
        cy = 0;
        quad = mid + 32'h4000_0000;
        if (quad[31]) begin
            cx  = -cx;
            mid = mid + 32'h8000_0000;
        end
        z = longint'($signed(mid));
        for (int k = 0; k < int'(steps) && k < 24; k++) begin
            sx = cx >>> k;
            sy = cy >>> k;
            if (z >= 0) begin
                cx = cx - sy;
                cy = cy + sx;
                z  = z - longint'(atan_tab[k]);
            end else begin
                cx = cx + sy;
                cy = cy - sx;
                z  = z + longint'(atan_tab[k]);
            end
        end
        tmp   = sat_q16(longint'($signed(x_acc)) + cx);
        x_acc = tmp[31:0];
        tmp   = sat_q16(longint'($signed(y_acc)) + cy);
        y_acc = tmp[31:0];
        heading_acc = heading_acc + dturn;
        queue_pose();
    endfunction

    task report(string what);
        errors++;
        // keep the log short on a badly broken block
        if (errors <= 100) begin
            $display("mismatch: %s", what);
        end
    endtask

    task check_pose(logic [31:0] x, logic [31:0] y, logic [15:0] h);
        pose_t want;
        string diff;
        checked++;
        if (poses_due.size() == 0) begin
            report($sformatf("pose beat x=%h y=%h hdg=%h with no count beat behind it",
                             x, y, h));
            return;
        end
        want = poses_due.pop_front();
        diff = "";
        if (x !== want.pos_x) begin
            diff = {diff, $sformatf(" x %h/%h", x, want.pos_x)};
        end
        if (y !== want.pos_y) begin
            diff = {diff, $sformatf(" y %h/%h", y, want.pos_y)};
        end
        if (h !== want.heading) begin
            diff = {diff, $sformatf(" hdg %h/%h", h, want.heading)};
        end
        if (diff != "") begin
            report($sformatf("pose beat %0d got/want:%s", checked, diff));
        end
    endtask
endclass

module tb_differential_drive_odometry;

    localparam int STEPS     = ddo_pkg::CORDIC_STEPS_DEF;
    localparam int SETTLE    = STEPS + 16;
    localparam int DRAIN_MAX = 4000;
    localparam int LONG_HOLD = 400;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_left_count  = '0;
    logic [31:0] i_right_count = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [31:0] o_pos_x;
    logic [31:0] o_pos_y;
    logic [15:0] o_heading;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = 1'b0;
    logic [31:0] i_cfg_data    = '0;

    pose_tracker tracker;
    bit          idle_on   = 1'b1;
    bit          hold_req  = 1'b0;
    int          rx_wait   = 0;
    int          beats_in  = 0;
    int          cfg_writes = 0;
    logic [31:0] cur_left  = '0;
    logic [31:0] cur_right = '0;

    differential_drive_odometry #(.CORDIC_STEPS(STEPS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_left_count  (i_left_count),
        .i_right_count (i_right_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_heading     (o_heading),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_pose(o_pos_x, o_pos_y, o_heading);
            rx_wait = idle_on ? int'($urandom_range(0, 4)) : 0;
        end
    end

    // receiver stall; a hold request blocks the output for a long stretch
    initial begin : out_side
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_wait > 0) begin
                i_out_stall <= 1'b1;
                rx_wait = rx_wait - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_counts(input logic [31:0] left, input logic [31:0] right);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 4)) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_left_count  <= left;
        i_right_count <= right;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_counts(left, right);
        beats_in++;
        cur_left  = left;
        cur_right = right;
        @(negedge i_clk);
    endtask

    task automatic move(input logic [31:0] dl, input logic [31:0] dr);
        send_counts(cur_left + dl, cur_right + dr);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_reg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // wait until every pose beat is back, then let the block go quiet
    task automatic settle_block();
        int n;
        i_in_valid <= 1'b0;
        n = 0;
        while (tracker.pending() != 0 && n < DRAIN_MAX) begin
            @(negedge i_clk);
            n++;
        end
        if (tracker.pending() != 0) begin
            tracker.report($sformatf("%0d pose beats never came out", tracker.pending()));
            tracker.poses_due.delete();
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_delta();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick <= 10) begin
            return $urandom_range(0, 4000) - 2000;
        end
        if (pick <= 12) begin
            return $urandom_range(0, 1 << 21) - (1 << 20);
        end
        if (pick == 13) begin
            return $urandom;
        end
        if (pick == 14) begin
            return 32'd0;
        end
        return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    task automatic run_phase(input int n);
        logic [31:0] dl, dr;
        int unsigned pick;
        repeat (n) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                // unrelated counts: a jump on both encoders
                send_counts($urandom, $urandom);
            end else begin
                dl = rand_delta();
                dr = (pick < 14) ? dl + ($urandom_range(0, 600) - 300) : rand_delta();
                move(dl, dr);
            end
        end
        settle_block();
    endtask

    initial begin : stimulus
        tracker = new(STEPS);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first beat after reset only latches
        send_counts(32'h8000_0000, 32'h7FFF_FFFF);
        move(0, 0);
        move(1000, 1000);
        move(-700, 700);
        move(-40000, 40000);     // midpoint heading lands past a quarter turn
        move(2500, 2600);
        move(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // mean distance clips
        move(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        move(32'h8000_0000, 32'h8000_0000);
        move(32'h7FFF_FFFF, 32'h8000_0000);   // opposed extremes, turn wraps
        send_counts(32'h0000_0000, 32'h0000_0000);
        send_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        settle_block();

        write_reg(ddo_pkg::CFG_DPT, 32'h0000_0000);
        move(5000, -3000);       // no travel, no turn
        settle_block();
        write_reg(ddo_pkg::CFG_DPT, 32'hFFFF_FFFF);
        write_reg(ddo_pkg::CFG_ITW, 32'h0000_0000);
        move(1234, 99999);
        move(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // drive x into its upper limit
        move(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        move(32'h8000_0000, 32'h8000_0000);   // and back into the lower one
        move(32'h8000_0000, 32'h8000_0000);
        move(32'h8000_0000, 32'h8000_0000);
        settle_block();
        write_reg(ddo_pkg::CFG_ITW, 32'hFFFF_FFFF);
        move(100, -100);
        move(-1, 1);
        move(32'h0001_0000, 32'hFFFF_0000);
        settle_block();

        write_reg(ddo_pkg::CFG_DPT, DPT_AT_RESET);
        write_reg(ddo_pkg::CFG_ITW, ITW_AT_RESET);
        run_phase(100);

        write_reg(ddo_pkg::CFG_DPT, $urandom);
        write_reg(ddo_pkg::CFG_ITW, $urandom_range(0, 1 << 20));
        idle_on = 1'b0;
        run_phase(80);
        idle_on = 1'b1;

        write_reg(ddo_pkg::CFG_DPT, $urandom_range(1 << 16, 1 << 24));
        write_reg(ddo_pkg::CFG_ITW, $urandom);
        // output blocked while counts keep coming, so the input backs up
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        run_phase(80);

        write_reg(ddo_pkg::CFG_DPT, $urandom);
        write_reg(ddo_pkg::CFG_ITW, $urandom);
        run_phase(80);

        write_reg(ddo_pkg::CFG_DPT, DPT_AT_RESET);
        write_reg(ddo_pkg::CFG_ITW, ITW_AT_RESET);
        run_phase(60);

        $display("summary: %0d count beats in, %0d pose beats checked, %0d errors",
                 beats_in, tracker.checked, tracker.errors);
        $display("summary: %0d register writes, zero and full-scale settings included",
                 cfg_writes);
        if (tracker.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
